/* rtl/core/slad_pkg.sv */
// ----------------------------------------------------------------------------
// Segment length and direction package
// Shared widths, limits and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package slad_pkg;

   // Default configuration of the coordinate and direction formats.
   localparam int DEF_COORD_WIDTH   = 24;
   localparam int DEF_DIR_FRAC_BITS = 14;

   // Fixed result field widths.
   localparam int DIR_W      = 16;
   localparam int SEG_W      = 25;
   localparam int TOTAL_W    = 48;
   localparam int RSP_DATA_W = 128;

   // Saturation limits of the length outputs.
   localparam logic [SEG_W-1:0]   SEG_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Root register width of the square root unit and dividend width of the divider.
   localparam int ROOT_W = 32;
   localparam int DIV_W  = 64;

   // Component selectors.
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       path_start;
      logic       capture;
      logic       mul_en;
      logic       acc_en;
      logic [1:0] mul_sel;
      logic       sqrt_init;
      logic       sqrt_run;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic [1:0] comp;
      logic       finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic have_prev;
      logic sq_zero;
      logic sqrt_done;
   } status_type;

endpackage

/* rtl/core/segment_length_and_direction_3d.sv */
// ----------------------------------------------------------------------------
// Segment length and direction, 3D
// Distance, unit direction and running path length between successive points.
// ----------------------------------------------------------------------------
// Each point that continues a path yields one result transaction: the rounded
// length of the move from the previous point (unsigned Q25.0, saturating), its unit
// direction (Q1.14 at the default DIR_FRAC_BITS, clamped to magnitude one) and
// the saturating path total. A restart point, and the first point after reset,
// only starts a new path. A repeated point reports zero_move with a zero
// direction. One point is in flight at a time. A moving point passes through
// setup and squaring, then the square root (one bit pair a cycle, with extra
// root bits past the integer root until it holds 31 significant bits), then
// three divisions on the shared divider, then loads the result register once
// that register is free. A zero move skips the root and the divisions. The next
// point is accepted while the previous result is still waiting on the output.
// ----------------------------------------------------------------------------
module segment_length_and_direction_3d
   import slad_pkg::*;
#(
   parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
   parameter int DIR_FRAC_BITS = DEF_DIR_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_x, point_y, point_z from the lowest bit up, zero padded to bytes
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // restart
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // dir_x, dir_y, dir_z, seg_length, path_total from the lowest bit up, zero padded
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // zero_move
   output logic                  rsp_tuser
);

   localparam int RSP_USED_W = 3 * DIR_W + SEG_W + TOTAL_W;

   cmd_type                cmd;
   status_type             status;
   logic [COORD_WIDTH-1:0] point_x, point_y, point_z;
   logic [DIR_W-1:0]       dir_x, dir_y, dir_z;
   logic [SEG_W-1:0]       seg_length;
   logic [TOTAL_W-1:0]     path_total;
   logic                   zero_move;

   // Unpack the request transaction.
   assign point_x = req_tdata[COORD_WIDTH-1:0];
   assign point_y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign point_z = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

   slad_ctrl #(
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tuser),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   slad_datapath #(
      .COORD_WIDTH   (COORD_WIDTH),
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .point_x    (point_x),
      .point_y    (point_y),
      .point_z    (point_z),
      .dir_x      (dir_x),
      .dir_y      (dir_y),
      .dir_z      (dir_z),
      .seg_length (seg_length),
      .path_total (path_total),
      .zero_move  (zero_move)
   );

   // Pack the response transaction.
   assign rsp_tdata = {(RSP_DATA_W - RSP_USED_W)'(0), path_total, seg_length,
                       dir_z, dir_y, dir_x};
   assign rsp_tuser = zero_move;

endmodule

/* rtl/core/slad_ctrl.sv */
// ----------------------------------------------------------------------------
// Segment length and direction controller
// Sequences the squaring, square root and three divisions of one transaction
// and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module slad_ctrl
   import slad_pkg::*;
#(
   parameter int DIR_FRAC_BITS = DEF_DIR_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_restart,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int CNT_W = $clog2(DIR_FRAC_BITS + 2);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIR_FRAC_BITS);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_SQRT,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_STORE,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       comp_ff, comp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state, counters and commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.comp     = comp_ff;
      cmd.mul_sel  = cnt_ff[1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart || !status.have_prev) begin
                  cmd.path_start = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  cnt_in      = '0;
                  state_in    = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // Three squares through one multiplier, accumulated in the cycle after.
            cmd.mul_en = (cnt_ff != MUL_LAST);
            cmd.acc_en = (cnt_ff != '0);
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_CHECK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            cmd.sqrt_init = 1'b1;
            comp_in       = COMP_X;
            state_in      = status.sq_zero ? ST_FINISH : ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_run = 1'b1;
            if (status.sqrt_done) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DIV_STORE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
            if (comp_ff == COMP_Z) begin
               state_in = ST_FINISH;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_DIV_LOAD;
            end
         end
         ST_FINISH: begin
            // The result register must be empty or emptying this cycle.
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         comp_ff      <= COMP_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is never written over one that has not been taken.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result register overwritten");

   // A point that continues a path always starts the squaring.
   a_capture_mul: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_restart && status.have_prev) |=> (state_ff == ST_MUL))
      else $error("continuing point did not start the datapath");

   // The square root hands over to the first division.
   a_sqrt_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && status.sqrt_done) |=> (state_ff == ST_DIV_LOAD))
      else $error("square root did not hand over to the divider");

endmodule

/* rtl/core/slad_datapath.sv */
// ----------------------------------------------------------------------------
// Segment length and direction datapath
// Point registers, shared squaring multiplier, digit-by-digit square root,
// restoring divider, path total and the result register.
// ----------------------------------------------------------------------------
module slad_datapath
   import slad_pkg::*;
#(
   parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
   parameter int DIR_FRAC_BITS = DEF_DIR_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [COORD_WIDTH-1:0] point_x,
   input  logic [COORD_WIDTH-1:0] point_y,
   input  logic [COORD_WIDTH-1:0] point_z,
   output logic [DIR_W-1:0]       dir_x,
   output logic [DIR_W-1:0]       dir_y,
   output logic [DIR_W-1:0]       dir_z,
   output logic [SEG_W-1:0]       seg_length,
   output logic [TOTAL_W-1:0]     path_total,
   output logic                   zero_move
);

   localparam int MAG_W  = COORD_WIDTH + 1;
   localparam int SQ_W   = (2 * COORD_WIDTH + 2 > 64) ? 64 : 2 * COORD_WIDTH + 2;
   localparam int SQ_P   = SQ_W / 2;
   localparam int STEP_W = $clog2(SQ_P + 33);
   localparam int REM_W  = ROOT_W + 3;
   localparam int Q_W    = DIR_FRAC_BITS + 1;
   localparam int QX_W   = (Q_W > DIR_W) ? Q_W : DIR_W;
   localparam int SH_W   = 6;
   localparam logic [STEP_W-1:0] INT_STEPS = STEP_W'(SQ_P);
   localparam logic [Q_W-1:0]    UNIT      = Q_W'(1) << DIR_FRAC_BITS;

   // Previous point and path state.
   logic [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic                   have_prev_ff;
   logic [TOTAL_W-1:0]     total_ff;

   // Deltas as sign and magnitude.
   logic [MAG_W-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic             neg_x_ff, neg_y_ff, neg_z_ff;

   // Squaring.
   logic [2*MAG_W-1:0] prod_ff;
   logic [SQ_W-1:0]    acc_ff;
   logic [MAG_W-1:0]   mul_mag;

   // Square root.
   logic [SQ_W-1:0]   rad_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SEG_W-1:0]  seg_ff;
   logic [REM_W-1:0]  rem_t, trial;
   logic              root_ge;
   logic              sqrt_done;

   // Divider.
   logic [DIV_W-1:0] dvd_ff, dvs_ff;
   logic [Q_W-1:0]   quo_ff;
   logic             clamp_ff;
   logic [MAG_W-1:0] div_mag;
   logic             div_neg;
   logic [SH_W-1:0]  div_shift;
   logic [DIV_W-1:0] div_num, div_start, div_limit;
   logic [Q_W-1:0]   q_sat;
   logic [QX_W-1:0]  q_ext, q_signed;
   logic [DIR_W-1:0] dir_x_ff, dir_y_ff, dir_z_ff;

   // Result register and length helpers.
   logic [DIR_W-1:0]   out_dx_ff, out_dy_ff, out_dz_ff;
   logic [SEG_W-1:0]   out_seg_ff;
   logic [TOTAL_W-1:0] out_total_ff;
   logic               out_zero_ff;
   logic [ROOT_W:0]    root_rnd;
   logic [TOTAL_W:0]   total_sum;
   logic [TOTAL_W-1:0] total_next;

   // Signed delta and its magnitude.
   function automatic logic [MAG_W:0] delta_of(input logic [COORD_WIDTH-1:0] cur,
                                               input logic [COORD_WIDTH-1:0] prv);
      logic [MAG_W-1:0] d;
      logic             neg;
      d   = {cur[COORD_WIDTH-1], cur} - {prv[COORD_WIDTH-1], prv};
      neg = d[MAG_W-1];
      return {neg, neg ? (~d + 1'b1) : d};
   endfunction

   assign status.have_prev = have_prev_ff;
   assign status.sq_zero   = (acc_ff == '0);
   assign status.sqrt_done = sqrt_done;

   // Point capture and delta computation.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (cmd.path_start) begin
         have_prev_ff <= 1'b1;
      end
      if (cmd.path_start || cmd.capture) begin
         prev_x_ff <= point_x;
         prev_y_ff <= point_y;
         prev_z_ff <= point_z;
      end
      if (cmd.capture) begin
         {neg_x_ff, mag_x_ff} <= delta_of(point_x, prev_x_ff);
         {neg_y_ff, mag_y_ff} <= delta_of(point_y, prev_y_ff);
         {neg_z_ff, mag_z_ff} <= delta_of(point_z, prev_z_ff);
      end
   end

   // Sum of squares through one shared multiplier.
   always_comb begin
      case (cmd.mul_sel)
         COMP_X:  mul_mag = mag_x_ff;
         COMP_Y:  mul_mag = mag_y_ff;
         default: mul_mag = mag_z_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_mag * mul_mag;
      end
      if (cmd.capture) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + SQ_W'(prod_ff);
      end
   end

   // Square root, one radicand bit pair a cycle. Past the integer root, zero
   // pairs extend the root until it holds 31 significant bits.
   assign rem_t     = {rem_ff[REM_W-3:0], rad_ff[SQ_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign root_ge   = (rem_t >= trial);
   assign sqrt_done = (step_ff >= INT_STEPS) && (root_ff[ROOT_W-1] || root_ff[ROOT_W-2]);
   assign root_rnd  = {1'b0, root_ff} + (ROOT_W + 1)'(rem_ff > REM_W'(root_ff));

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         rad_ff  <= acc_ff;
         root_ff <= '0;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.sqrt_run && !sqrt_done) begin
         rad_ff  <= rad_ff << 2;
         root_ff <= {root_ff[ROOT_W-2:0], root_ge};
         rem_ff  <= root_ge ? (rem_t - trial) : rem_t;
         step_ff <= step_ff + 1'b1;
      end
      // Rounded and saturated length, taken at the integer root.
      if (cmd.sqrt_run && step_ff == INT_STEPS) begin
         seg_ff <= (root_rnd > (ROOT_W + 1)'(SEG_MAX)) ? SEG_MAX : root_rnd[SEG_W-1:0];
      end
   end

   // Divider operand selection and alignment.
   always_comb begin
      case (cmd.comp)
         COMP_X:  begin div_mag = mag_x_ff; div_neg = neg_x_ff; end
         COMP_Y:  begin div_mag = mag_y_ff; div_neg = neg_y_ff; end
         default: begin div_mag = mag_z_ff; div_neg = neg_z_ff; end
      endcase
      div_shift = SH_W'(DIR_FRAC_BITS) + SH_W'(step_ff - INT_STEPS);
      div_num   = DIV_W'(div_mag) << div_shift;
      div_start = div_num + DIV_W'(root_ff >> 1);
      div_limit = DIV_W'(root_ff) << (DIR_FRAC_BITS + 1);
      q_sat     = (clamp_ff || quo_ff > UNIT) ? UNIT : quo_ff;
      q_ext     = QX_W'(q_sat);
      q_signed  = div_neg ? (~q_ext + 1'b1) : q_ext;
   end

   // Restoring division, one quotient bit a cycle, with early clamp detection.
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dvd_ff   <= div_start;
         dvs_ff   <= DIV_W'(root_ff) << DIR_FRAC_BITS;
         quo_ff   <= '0;
         clamp_ff <= (div_start >= div_limit);
      end else if (cmd.div_step) begin
         if (dvd_ff >= dvs_ff) begin
            dvd_ff <= dvd_ff - dvs_ff;
         end
         quo_ff <= {quo_ff[Q_W-2:0], dvd_ff >= dvs_ff};
         dvs_ff <= dvs_ff >> 1;
      end
      if (cmd.div_store) begin
         case (cmd.comp)
            COMP_X:  dir_x_ff <= q_signed[DIR_W-1:0];
            COMP_Y:  dir_y_ff <= q_signed[DIR_W-1:0];
            default: dir_z_ff <= q_signed[DIR_W-1:0];
         endcase
      end
   end

   // Saturating path total.
   assign total_sum  = {1'b0, total_ff} + (TOTAL_W + 1)'(seg_ff);
   assign total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

   // Path total and result register.
   always_ff @(posedge clock) begin
      if (cmd.path_start) begin
         total_ff <= '0;
      end else if (cmd.finish && !status.sq_zero) begin
         total_ff <= total_next;
      end
      if (cmd.finish) begin
         if (status.sq_zero) begin
            out_dx_ff    <= '0;
            out_dy_ff    <= '0;
            out_dz_ff    <= '0;
            out_seg_ff   <= '0;
            out_total_ff <= total_ff;
            out_zero_ff  <= 1'b1;
         end else begin
            out_dx_ff    <= dir_x_ff;
            out_dy_ff    <= dir_y_ff;
            out_dz_ff    <= dir_z_ff;
            out_seg_ff   <= seg_ff;
            out_total_ff <= total_next;
            out_zero_ff  <= 1'b0;
         end
      end
   end

   assign dir_x      = out_dx_ff;
   assign dir_y      = out_dy_ff;
   assign dir_z      = out_dz_ff;
   assign seg_length = out_seg_ff;
   assign path_total = out_total_ff;
   assign zero_move  = out_zero_ff;

   // A nonzero squared length always rounds to a length of at least one.
   a_seg_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !status.sq_zero) |-> (seg_ff != '0))
      else $error("nonzero move produced a zero length");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Segment length and direction testbench
// Streams 3D points into the block, predicts every move's length, unit
// direction, path total and zero-move flag, and checks each result
// transaction in order. Both channels idle at random, and the result channel
// is held off once for a long stretch so the input has to stall.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import slad_pkg::*;

   localparam int CW           = DEF_COORD_WIDTH;
   localparam int FRAC         = DEF_DIR_FRAC_BITS;
   localparam int REQ_W        = ((3*CW+7)/8)*8;
   localparam int SEG_LSB      = 3*DIR_W;
   localparam int TOTAL_LSB    = SEG_LSB + SEG_W;
   localparam int NUM_POINTS   = 1150;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_POINTS  = 8;
   localparam int DRAIN_CYCLES = 200;
   localparam int QUIET_LIMIT  = 5000;

   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 restart;
   } point_type;

   typedef struct {
      logic [DIR_W-1:0]   dir_x;
      logic [DIR_W-1:0]   dir_y;
      logic [DIR_W-1:0]   dir_z;
      logic [SEG_W-1:0]   seg_length;
      logic [TOTAL_W-1:0] path_total;
      logic               zero_move;
   } move_result_type;

   // Tracks the path the same way the block does and queues the expected moves.
   class path_scoreboard_type;
      logic signed [CW-1:0] last_x, last_y, last_z;
      bit                   started;
      bit [TOTAL_W-1:0]     run_total;
      move_result_type      pending[$];
      int unsigned          errors, points, path_starts, moves, zero_moves;

      function new();
         last_x = '0;
         last_y = '0;
         last_z = '0;
         started = 1'b0;
         run_total = '0;
      endfunction

      // Bitwise integer square root, rounded down.
      static function bit [63:0] root_floor(bit [63:0] v);
         bit [63:0] acc, probe;
         acc = '0;
         probe = 64'd1 << 62;
         while (probe > v) probe >>= 2;
         while (probe != 0) begin
            if (v >= acc + probe) begin
               v -= acc + probe;
               acc = (acc >> 1) + probe;
            end else begin
               acc >>= 1;
            end
            probe >>= 2;
         end
         return acc;
      endfunction

      // One direction component: rounded quotient, clamped to one, sign restored.
      static function logic [DIR_W-1:0] unit_part(longint d, int unsigned k, bit [63:0] lx);
         bit [63:0] mag, q;
         mag = (d < 0) ? -d : d;
         q = ((mag << (FRAC + k)) + (lx >> 1)) / lx;
         if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
         if (d < 0) q = -q;
         return q[DIR_W-1:0];
      endfunction

      function void note_point(point_type p);
         longint          dx, dy, dz;
         bit [63:0]       ax, ay, az, sq, len, lx, probe;
         int unsigned     nbits, k;
         move_result_type r;
         points++;
         // A restart, or the first point after reset, only opens a new path.
         if (p.restart || !started) begin
            path_starts++;
            last_x = p.x;
            last_y = p.y;
            last_z = p.z;
            started = 1'b1;
            run_total = '0;
            return;
         end
         dx = longint'(p.x) - longint'(last_x);
         dy = longint'(p.y) - longint'(last_y);
         dz = longint'(p.z) - longint'(last_z);
         last_x = p.x;
         last_y = p.y;
         last_z = p.z;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         az = (dz < 0) ? -dz : dz;
         sq = ax*ax + ay*ay + az*az;
         if (sq == 0) begin
            // Repeated point: zero direction, the total stays as it was.
            r.dir_x = '0;
            r.dir_y = '0;
            r.dir_z = '0;
            r.seg_length = '0;
            r.path_total = run_total;
            r.zero_move = 1'b1;
         end else begin
            len = root_floor(sq);
            if (sq - len*len > len) len++;
            if (len > SEG_MAX) len = SEG_MAX;
            // Scale the square up by an even shift so the root has full precision.
            nbits = 0;
            for (probe = sq; probe != 0; probe >>= 1) nbits++;
            k = (nbits < 62) ? (62 - nbits) / 2 : 0;
            lx = root_floor(sq << (2*k));
            r.dir_x = unit_part(dx, k, lx);
            r.dir_y = unit_part(dy, k, lx);
            r.dir_z = unit_part(dz, k, lx);
            if (run_total > TOTAL_MAX - len) run_total = TOTAL_MAX;
            else run_total = TOTAL_W'(run_total + len);
            r.seg_length = len[SEG_W-1:0];
            r.path_total = run_total;
            r.zero_move = 1'b0;
         end
         pending.push_back(r);
      endfunction

      task report_mismatch(string what, bit [63:0] got, bit [63:0] want);
         errors++;
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      task check_result(logic [RSP_DATA_W-1:0] data, logic zero_flag);
         move_result_type want;
         moves++;
         if (pending.size() == 0) begin
            report_mismatch("result with nothing pending", data[63:0], '0);
            return;
         end
         want = pending.pop_front();
         if (want.zero_move) zero_moves++;
         if (data[0 +: DIR_W] !== want.dir_x)
            report_mismatch("dir_x", 64'(data[0 +: DIR_W]), 64'(want.dir_x));
         if (data[DIR_W +: DIR_W] !== want.dir_y)
            report_mismatch("dir_y", 64'(data[DIR_W +: DIR_W]), 64'(want.dir_y));
         if (data[2*DIR_W +: DIR_W] !== want.dir_z)
            report_mismatch("dir_z", 64'(data[2*DIR_W +: DIR_W]), 64'(want.dir_z));
         if (data[SEG_LSB +: SEG_W] !== want.seg_length)
            report_mismatch("seg_length", 64'(data[SEG_LSB +: SEG_W]),
                            64'(want.seg_length));
         if (data[TOTAL_LSB +: TOTAL_W] !== want.path_total)
            report_mismatch("path_total", 64'(data[TOTAL_LSB +: TOTAL_W]),
                            64'(want.path_total));
         if (zero_flag !== want.zero_move)
            report_mismatch("zero_move", 64'(zero_flag), 64'(want.zero_move));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;   // point_x, point_y, point_z from the lowest bit up
   logic                  req_tuser;   // restart
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // dir_x, dir_y, dir_z, seg_length, path_total, padding
   logic                  rsp_tuser;   // zero_move

   path_scoreboard_type sb;
   point_type           cursor;
   bit                  no_idle;
   bit                  hold_request;
   int unsigned         sent;

   segment_length_and_direction_3d u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none during burst phases.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 150);
   endfunction

   function automatic logic signed [CW-1:0] any_coord();
      return CW'($urandom());
   endfunction

   function automatic logic signed [CW-1:0] corner_coord();
      case ($urandom_range(0, 4))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3: return '1;
         default: return CW'(1);
      endcase
   endfunction

   // Moves a coordinate by a small signed step; it wraps at the ends of the range.
   function automatic logic signed [CW-1:0] nudge(logic signed [CW-1:0] c, int unsigned span);
      int off;
      off = int'($urandom_range(0, 2*span)) - int'(span);
      return CW'(c + off);
   endfunction

   // Offers one point, waits for the transaction, then idles for a random gap.
   task automatic send_point(input logic signed [CW-1:0] x, y, z, input logic rs);
      point_type   p;
      int unsigned gap;
      p.x = x;
      p.y = y;
      p.z = z;
      p.restart = rs;
      req_tdata <= REQ_W'({z, y, x});
      req_tuser <= rs;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_point(p);
      sent++;
      cursor = p;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // A move from the last point: repeats, small and tiny steps, single-axis
   // jumps, corners of the range and fully random points.
   task automatic send_move();
      logic signed [CW-1:0] x, y, z;
      int unsigned          pick;
      x = cursor.x;
      y = cursor.y;
      z = cursor.z;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // Same point again.
      end else if (pick < 40) begin
         x = nudge(x, 1000);
         y = nudge(y, 1000);
         z = nudge(z, 1000);
      end else if (pick < 55) begin
         case ($urandom_range(0, 2))
            0: x = any_coord();
            1: y = any_coord();
            default: z = any_coord();
         endcase
      end else if (pick < 65) begin
         x = nudge(x, 3);
         y = nudge(y, 3);
         z = nudge(z, 3);
      end else if (pick < 75) begin
         x = corner_coord();
         y = corner_coord();
         z = corner_coord();
      end else begin
         x = any_coord();
         y = any_coord();
         z = any_coord();
      end
      send_point(x, y, z, 1'b0);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : rsp_side
      int unsigned wait_left;
      wait_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (wait_left > 0) begin
            rsp_tready <= 1'b0;
            wait_left--;
         end else if (no_idle || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            wait_left = pick_gap();
         end
      end
   end

   // Every accepted result transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Ends the run when neither channel has moved for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned moves_left;
      int unsigned held_at;
      bit          held;
      sb = new();
      held = 1'b0;
      held_at = 0;
      sent = 0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The first point opens a path even without restart.
      send_point('0, '0, '0, 1'b0);
      send_point(COORD_MAX, '0, '0, 1'b0);
      send_point(COORD_MAX, '0, '0, 1'b0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MIN, '0, 1'b0);
      // Back-to-back restarts, then unit steps along each axis.
      send_point('0, '0, '0, 1'b1);
      send_point('0, '0, '0, 1'b1);
      send_point(CW'(-1), '0, '0, 1'b0);
      send_point(CW'(-1), CW'(1), '0, 1'b0);
      send_point(CW'(-1), CW'(1), CW'(-1), 1'b0);
      send_point('0, CW'(2), '0, 1'b0);
      send_point(CW'(3), CW'(6), CW'(2), 1'b0);
      send_point(CW'(3), CW'(6), CW'(2), 1'b0);
      // Restart on the same point clears the total without a result.
      send_point(CW'(3), CW'(6), CW'(2), 1'b1);
      send_point(CW'(6), CW'(10), CW'(2), 1'b0);
      send_point(COORD_MIN, '0, '0, 1'b0);
      send_point(COORD_MIN, COORD_MAX, '0, 1'b0);
      send_point('0, '0, COORD_MAX, 1'b0);
      send_point('0, '0, COORD_MIN, 1'b0);

      // Random paths: mostly a restart followed by moves, with some stray
      // restarts and some paths that open without the restart flag.
      while (sent < NUM_POINTS) begin
         // The sender stays gapless for a while after the hold-off starts.
         if (!held || sent > held_at + HOLD_POINTS)
            no_idle = ($urandom_range(0, 3) == 0);
         if (!held && sent >= NUM_POINTS/2) begin
            held = 1'b1;
            held_at = sent;
            hold_request = 1'b1;
            no_idle = 1'b1;
         end
         if ($urandom_range(0, 9) == 0)
            send_point(corner_coord(), corner_coord(), corner_coord(),
                       $urandom_range(0, 19) != 0);
         else
            send_point(any_coord(), any_coord(), any_coord(), $urandom_range(0, 19) != 0);
         moves_left = $urandom_range(0, 30);
         while (moves_left > 0 && sent < NUM_POINTS) begin
            if ($urandom_range(0, 99) < 4)
               send_point(any_coord(), any_coord(), any_coord(), 1'b1);
            else
               send_move();
            moves_left--;
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d points (%0d path starts); checked %0d moves, %0d of them zero-length.",
               sb.points, sb.path_starts, sb.moves, sb.zero_moves);
      $display("Random idling on both channels and one %0d-cycle result hold-off; %0d mismatches.",
               HOLD_CYCLES, sb.errors);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
